// ----- sv/bakp_pkg.sv -----
// types and constants for the block argmax keypoint picker
// used by block_argmax_keypoint_picker; no dependencies
package bakp_pkg;

  localparam int VAL_W = 36;
  localparam int CFG_W = 36;
  localparam int CFG_IDX_W = 2;
  localparam int DIM_W = 12;
  localparam int SHIFT_W = 3;
  localparam int OFS_W = 5;
  localparam int POS_W = 11;
  localparam int BIDX_W = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W = 3;
  localparam int QIDX_W = 2;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  localparam logic [DIM_W-1:0] WIDTH_RESET = 12'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd4;
  localparam logic [SHIFT_W-1:0] SHIFT_LO = 3'd3;
  localparam logic [SHIFT_W-1:0] SHIFT_HI = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SHIFT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RESPONSE = 2'd3;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] value;
    logic [OFS_W-1:0]        dx;
    logic [OFS_W-1:0]        dy;
  } entry_t;

  typedef struct packed {
    logic [BIDX_W-1:0]       bcol;
    logic [BIDX_W-1:0]       brow;
    logic                    found;
    logic [POS_W-1:0]        bx;
    logic [POS_W-1:0]        by;
    logic signed [VAL_W-1:0] value;
  } result_t;

endpackage

// ----- sv/block_argmax_keypoint_picker.sv -----
// block argmax keypoint picker, top level
// per-block-column best-response memory with read-modify-write and forwarding
// depends on bakp_pkg
//
// Takes one corner-response pixel per clock in raster order, unless in_stall
// is high, and, on the last pixel of each square block, reports the strongest
// gained response above min_response with its absolute position (earliest
// pixel wins ties). One pixel is accepted every cycle while in_stall is low;
// the pace is set by the per-block-column memory, read in stage a and
// written back in stage b, with the write forwarded when the following pixel
// hits the same block column. A result passes stages a and b and then waits
// in a four-entry output queue; in_stall rises only when that queue, counting
// pixels still in flight, could overflow. The per-slot valid bits come out of
// reset cleared, so no clearing pass is needed.
module block_argmax_keypoint_picker #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_BLOCK_COLUMNS = 256,
  parameter int GAIN_SHIFT = 4
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration
  input  logic                                   cfg_write,
  input  logic [bakp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [bakp_pkg::CFG_W-1:0]             cfg_data,
  // pixel input
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [31:0]                     response_value,
  input  logic                                   frame_start,
  // block results
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [bakp_pkg::BIDX_W-1:0]            block_col,
  output logic [bakp_pkg::BIDX_W-1:0]            block_row,
  output logic                                   found,
  output logic [bakp_pkg::POS_W-1:0]             best_x,
  output logic [bakp_pkg::POS_W-1:0]             best_y,
  output logic signed [bakp_pkg::VAL_W-1:0]      best_response
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int CMPW = (WW > bakp_pkg::DIM_W) ? WW : bakp_pkg::DIM_W;
  localparam int SW = (MAX_BLOCK_COLUMNS > 1) ? $clog2(MAX_BLOCK_COLUMNS) : 1;
  localparam int RW = CW + 1;

  // configuration registers
  logic [bakp_pkg::DIM_W-1:0]         image_width;
  logic [bakp_pkg::DIM_W-1:0]         image_height;
  logic [bakp_pkg::SHIFT_W-1:0]       block_shift;
  logic signed [bakp_pkg::VAL_W-1:0]  min_response;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= bakp_pkg::WIDTH_RESET;
      image_height <= bakp_pkg::HEIGHT_RESET;
      block_shift <= bakp_pkg::SHIFT_RESET;
      min_response <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        bakp_pkg::REG_IMAGE_WIDTH: begin
          image_width <= cfg_data[bakp_pkg::DIM_W-1:0];
        end
        bakp_pkg::REG_IMAGE_HEIGHT: begin
          image_height <= cfg_data[bakp_pkg::DIM_W-1:0];
        end
        bakp_pkg::REG_BLOCK_SHIFT: begin
          block_shift <= cfg_data[bakp_pkg::SHIFT_W-1:0];
        end
        bakp_pkg::REG_MIN_RESPONSE: begin
          min_response <= signed'(cfg_data[bakp_pkg::VAL_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  // clamped configuration
  logic [WW-1:0]                 w_eff;
  logic [WW-1:0]                 h_eff;
  logic [bakp_pkg::SHIFT_W-1:0]  bs;
  logic [bakp_pkg::OFS_W-1:0]    lmask;

  always_comb begin
    if (image_width == '0) begin
      w_eff = WW'(1);
    end else if (CMPW'(image_width) > CMPW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    if (image_height == '0) begin
      h_eff = WW'(1);
    end else if (CMPW'(image_height) > CMPW'(MAX_WIDTH)) begin
      h_eff = WW'(MAX_WIDTH);
    end else begin
      h_eff = WW'(image_height);
    end
    if (block_shift < bakp_pkg::SHIFT_LO) begin
      bs = bakp_pkg::SHIFT_LO;
    end else if (block_shift > bakp_pkg::SHIFT_HI) begin
      bs = bakp_pkg::SHIFT_HI;
    end else begin
      bs = block_shift;
    end
    lmask = bakp_pkg::OFS_W'((6'd1 << bs) - 6'd1);
  end

  // block column to memory slot, modulo MAX_BLOCK_COLUMNS by compare and subtract
  function automatic logic [SW-1:0] slot_of(input logic [CW-1:0] v);
    logic [RW-1:0] rem;
    rem = RW'(v);
    for (int k = CW; k >= 0; k--) begin
      if (32'(rem) >= 32'(MAX_BLOCK_COLUMNS << k)) begin
        rem = rem - RW'(MAX_BLOCK_COLUMNS << k);
      end
    end
    return SW'(rem);
  endfunction

  // ---------------- scan position ----------------
  logic [CW-1:0] col_count;
  logic [CW-1:0] row_count;
  logic [WW-1:0] c0, r0, r1, pos_col, pos_row, col_inc, row_inc;
  logic [CW-1:0] col_count_next, row_count_next;
  logic          accept;

  assign accept = in_valid && !in_stall;

  always_comb begin
    c0 = frame_start ? '0 : WW'(col_count);
    r0 = frame_start ? '0 : WW'(row_count);
    if (c0 >= w_eff) begin
      pos_col = '0;
      r1 = r0 + WW'(1);
    end else begin
      pos_col = c0;
      r1 = r0;
    end
    pos_row = (r1 >= h_eff) ? '0 : r1;
    col_inc = pos_col + WW'(1);
    row_inc = pos_row + WW'(1);
    if (col_inc >= w_eff) begin
      col_count_next = '0;
      row_count_next = (row_inc >= h_eff) ? '0 : CW'(row_inc);
    end else begin
      col_count_next = CW'(col_inc);
      row_count_next = CW'(pos_row);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // ---------------- stage a: block geometry, gain, memory read ----------------
  logic                 a_valid;
  logic [CW-1:0]        a_col;
  logic [CW-1:0]        a_row;
  logic signed [31:0]   a_resp;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_col <= CW'(pos_col);
      a_row <= CW'(pos_row);
      a_resp <= response_value;
    end
  end

  logic [CW-1:0]                      a_bc, a_br;
  logic [bakp_pkg::OFS_W-1:0]         a_lx, a_ly;
  logic [SW-1:0]                      a_slot;
  logic                               a_first, a_last;
  logic signed [63:0]                 a_gain;
  logic signed [bakp_pkg::VAL_W-1:0]  a_r;

  always_comb begin
    a_bc = a_col >> bs;
    a_br = a_row >> bs;
    a_lx = bakp_pkg::OFS_W'(a_col) & lmask;
    a_ly = bakp_pkg::OFS_W'(a_row) & lmask;
    a_slot = slot_of(a_bc);
    a_first = (a_lx == '0) && (a_ly == '0);
    a_last = ((a_lx == lmask) || (WW'(a_col) + WW'(1) == w_eff)) &&
             ((a_ly == lmask) || (WW'(a_row) + WW'(1) == h_eff));
    a_gain = 64'(a_resp) <<< GAIN_SHIFT;
    // saturate to the 36-bit range
    if (a_gain > 64'(bakp_pkg::VAL_MAX)) begin
      a_r = bakp_pkg::VAL_MAX;
    end else if (a_gain < 64'(bakp_pkg::VAL_MIN)) begin
      a_r = bakp_pkg::VAL_MIN;
    end else begin
      a_r = bakp_pkg::VAL_W'(a_gain);
    end
  end

  // ---------------- stage b: compare and write back ----------------
  logic                               b_valid;
  logic [SW-1:0]                      b_slot;
  logic [CW-1:0]                      b_bc, b_br;
  logic [bakp_pkg::OFS_W-1:0]         b_lx, b_ly;
  logic signed [bakp_pkg::VAL_W-1:0]  b_r;
  logic                               b_first, b_last;
  bakp_pkg::entry_t                   b_rd;
  logic                               b_vbit;
  logic                               b_fwd;
  bakp_pkg::entry_t                   b_fwd_entry;

  bakp_pkg::entry_t                   best_mem [MAX_BLOCK_COLUMNS];
  logic [MAX_BLOCK_COLUMNS-1:0]       entry_valid;

  bakp_pkg::entry_t                   old_entry, new_entry;
  logic                               old_found, b_qual, b_update;
  bakp_pkg::result_t                  b_res;
  logic [31:0]                        x_full, y_full;

  always_comb begin
    if (b_fwd) begin
      old_entry = b_fwd_entry;
    end else begin
      old_entry = b_rd;
    end
    // a never-written entry reads as not found
    old_found = b_first ? 1'b0 : (b_fwd ? b_fwd_entry.found : (b_vbit && b_rd.found));
    b_qual = b_r > min_response;
    b_update = b_qual && (!old_found || (b_r > old_entry.value));
    if (b_update) begin
      new_entry.found = 1'b1;
      new_entry.value = b_r;
      new_entry.dx = b_lx;
      new_entry.dy = b_ly;
    end else begin
      new_entry.found = old_found;
      new_entry.value = old_entry.value;
      new_entry.dx = old_entry.dx;
      new_entry.dy = old_entry.dy;
    end
    x_full = (32'(b_bc) << bs) + 32'(new_entry.dx);
    y_full = (32'(b_br) << bs) + 32'(new_entry.dy);
    b_res.bcol = bakp_pkg::BIDX_W'(b_bc);
    b_res.brow = bakp_pkg::BIDX_W'(b_br);
    b_res.found = new_entry.found;
    if (new_entry.found) begin
      b_res.bx = x_full[bakp_pkg::POS_W-1:0];
      b_res.by = y_full[bakp_pkg::POS_W-1:0];
      b_res.value = new_entry.value;
    end else begin
      b_res.bx = '0;
      b_res.by = '0;
      b_res.value = bakp_pkg::VAL_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_slot <= a_slot;
    b_bc <= a_bc;
    b_br <= a_br;
    b_lx <= a_lx;
    b_ly <= a_ly;
    b_r <= a_r;
    b_first <= a_first;
    b_last <= a_last;
    b_vbit <= entry_valid[a_slot];
    // write of the pixel ahead lands on the same edge as this read
    b_fwd <= b_valid && (b_slot == a_slot);
    b_fwd_entry <= new_entry;
  end

  always_ff @(posedge clk) begin
    b_rd <= best_mem[a_slot];
    if (b_valid) begin
      best_mem[b_slot] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (b_valid) begin
      entry_valid[b_slot] <= 1'b1;
    end
  end

  // ---------------- output queue ----------------
  bakp_pkg::result_t           q [bakp_pkg::QUEUE_DEPTH];
  logic [bakp_pkg::QCNT_W-1:0] q_count;
  logic                        q_push, q_pop;
  logic [bakp_pkg::QIDX_W-1:0] q_wr_idx;

  assign q_push = b_valid && b_last;
  assign q_pop = (q_count != '0) && !out_stall;
  assign q_wr_idx = bakp_pkg::QIDX_W'(q_count - bakp_pkg::QCNT_W'(q_pop));

  // room for every transaction still in flight, so nothing is dropped
  assign in_stall = (4'(q_count) + 4'(a_valid) + 4'(q_push)) >= 4'(bakp_pkg::QUEUE_DEPTH);

  // each entry takes the new result or shifts down, never both
  always_ff @(posedge clk) begin
    for (int i = 0; i < bakp_pkg::QUEUE_DEPTH - 1; i++) begin
      if (q_push && (q_wr_idx == bakp_pkg::QIDX_W'(i))) begin
        q[i] <= b_res;
      end else if (q_pop) begin
        q[i] <= q[i+1];
      end
    end
    if (q_push && (q_wr_idx == bakp_pkg::QIDX_W'(bakp_pkg::QUEUE_DEPTH - 1))) begin
      q[bakp_pkg::QUEUE_DEPTH-1] <= b_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= '0;
    end else begin
      q_count <= q_count + bakp_pkg::QCNT_W'(q_push) - bakp_pkg::QCNT_W'(q_pop);
    end
  end

  assign out_valid = (q_count != '0);
  assign block_col = q[0].bcol;
  assign block_row = q[0].brow;
  assign found = q[0].found;
  assign best_x = q[0].bx;
  assign best_y = q[0].by;
  assign best_response = q[0].value;

endmodule
